>>> rtl/p2d_pkg.sv
package p2d_pkg;

  // fixed formats
  localparam int MAX_ORDER = 7;
  localparam int FRAC_BITS = 20;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int COEF_W    = 32;
  localparam int COORD_W   = 24;
  localparam int ACC_W     = 64;
  localparam int PROD_W    = ACC_W + COEF_W;

  localparam logic [ACC_W-1:0] ONE_Q   = {{(ACC_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // item kinds on in_tuser
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_t;

  // register indexes on the apb port
  typedef enum logic {
    REG_POLY_ORDER = 1'b0,
    REG_FULL_GRID  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  a;
    logic signed [COEF_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic                    sat;
    logic signed [ACC_W-1:0] res;
  } mul_rsp_t;

endpackage

>>> rtl/p2d_coef_mem.sv
module p2d_coef_mem (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [p2d_pkg::ADDR_W-1:0]         wr_addr,
  input  logic [p2d_pkg::COEF_W-1:0]         wr_data,
  input  logic [p2d_pkg::ADDR_W-1:0]         rd_addr,
  output logic [p2d_pkg::COEF_W-1:0]         rd_data
);

  logic [p2d_pkg::COEF_W-1:0] mem [p2d_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/p2d_mulsh.sv
module p2d_mulsh (
  input  logic              clk,
  input  logic              rst_n,
  input  p2d_pkg::mul_req_t req,
  output p2d_pkg::mul_rsp_t rsp
);

  localparam int PW = p2d_pkg::PROD_W;
  localparam int AW = p2d_pkg::ACC_W;
  localparam int HW = AW / 2;
  localparam int BW = p2d_pkg::COEF_W;
  localparam int FB = p2d_pkg::FRAC_BITS;

  logic [1:0]              ph_r;
  logic signed [AW-1:0]    a_r;
  logic signed [BW-1:0]    b_r;
  logic signed [HW+BW:0]   plo_r;
  logic signed [HW+BW-1:0] phi_r;
  logic                    done_r;
  logic                    sat_r;
  logic signed [AW-1:0]    res_r;

  logic signed [PW-1:0]    full;
  logic [PW-1:FB+AW-1]     top_bits;
  logic                    ovf;

  // exact product from the two partial products, then floor shift and clamp
  assign full     = {phi_r, {HW{1'b0}}} + {{(PW-HW-BW-1){plo_r[HW+BW]}}, plo_r};
  assign top_bits = full[PW-1:FB+AW-1];
  assign ovf      = !((&top_bits) || !(|top_bits));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        2'd0: begin
          if (req.start) begin
            a_r  <= req.a;
            b_r  <= req.b;
            ph_r <= 2'd1;
          end
        end
        2'd1: begin
          plo_r <= $signed({1'b0, a_r[HW-1:0]}) * b_r;
          ph_r  <= 2'd2;
        end
        2'd2: begin
          phi_r <= $signed(a_r[AW-1:HW]) * b_r;
          ph_r  <= 2'd3;
        end
        default: begin
          done_r <= 1'b1;
          sat_r  <= ovf;
          if (ovf) begin
            res_r <= full[PW-1] ? p2d_pkg::SAT_MIN : p2d_pkg::SAT_MAX;
          end else begin
            res_r <= full[FB+AW-1:FB];
          end
          ph_r <= 2'd0;
        end
      endcase
    end
  end

  assign rsp.busy = (ph_r != 2'd0);
  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.res  = res_r;

endmodule

>>> rtl/poly2d_evaluator.sv
// poly2d_evaluator: value = sum of c[i][j] * x^i * y^j at one point per beat
//
// input stream: in_tuser selects the beat kind. a load beat (0) writes one
// coefficient into the 64-entry store at x_power*8+y_power and gives no
// result. an evaluate beat (1) takes x_coord, y_coord (Q4.20) and returns
// one output beat: value (Q44.20) and a saturated flag in out_tuser.
// configuration: apb, poly_order at 0x0, full_grid at 0x4, always ready.
// terms run row by row (y power outer, x power inner); the triangular set
// keeps i+j <= order, the full grid i,j <= order.
// multiply: every product goes through one shared multiply unit that takes
// a 64 by 32 bit product as a 33x32 and a 32x32 partial product plus a
// combine step. a term is an x step (none for the first term of a row) and
// a coefficient product; every row after the first adds a y step, and the
// evaluation also has a row start and an output step. the next beat is
// taken from the cycle the result appears. a load beat does not hold off
// the next beat; one item at a time.
// the result waits in an output register: a stalled receiver does not stop
// the next beat from being accepted, but a second result waits for the first.
// reset clears control state and the registers; the coefficient store is not
// cleared, every coefficient an evaluation uses must be loaded first.
module poly2d_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: x_power[2:0], y_power[5:3], coefficient[37:6],
  //           x_coord[61:38], y_coord[85:62], zero pad[87:86]
  input  logic [87:0] in_tdata,
  // in_tuser: mode[0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: value[63:0]
  output logic [63:0] out_tdata,
  // out_tuser: saturated[0]
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = p2d_pkg::IDX_W;
  localparam int AW = p2d_pkg::ACC_W;
  localparam int CW = p2d_pkg::COEF_W;
  localparam int XW = p2d_pkg::COORD_W;
  localparam logic [IW-1:0] MAX_ORD = IW'(p2d_pkg::MAX_ORDER);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_YWAIT,
    S_TERM,
    S_XWAIT,
    S_CMUL,
    S_CWAIT,
    S_OUT
  } state_t;

  state_t              state_r;
  logic [IW-1:0]       poly_order_r;
  logic                full_grid_r;
  logic [IW-1:0]       i_r;
  logic [IW-1:0]       j_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [AW-1:0] ypow_r;
  logic signed [AW-1:0] xpow_r;
  logic signed [AW-1:0] acc_r;
  logic                sat_r;
  logic                out_valid_r;
  logic [AW-1:0]       out_value_r;
  logic                out_sat_r;

  logic                in_acc;
  logic                cfg_wr;
  logic [IW-1:0]       ord;
  logic [IW-1:0]       ilim;
  logic [CW-1:0]       coef_rdata;
  logic signed [AW-1:0] acc_sum;
  logic                acc_ovf;
  logic signed [AW-1:0] acc_nxt;
  p2d_pkg::mul_req_t   mreq;
  p2d_pkg::mul_rsp_t   mrsp;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (p2d_pkg::reg_idx_t'(cfg_paddr[2]))
      p2d_pkg::REG_POLY_ORDER: cfg_prdata = {{(32-IW){1'b0}}, poly_order_r};
      p2d_pkg::REG_FULL_GRID:  cfg_prdata = {31'd0, full_grid_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // order in use and last x power of the current row
  assign ord  = (poly_order_r > MAX_ORD) ? MAX_ORD : poly_order_r;
  assign ilim = full_grid_r ? ord : ord - j_r;

  // ---------------------------------------------------------------- store
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  p2d_coef_mem u_mem (
    .clk     (clk),
    .wr_en   (in_acc && (p2d_pkg::mode_t'(in_tuser) == p2d_pkg::MODE_LOAD)),
    .wr_addr ({in_tdata[2:0], in_tdata[5:3]}),
    .wr_data (in_tdata[37:6]),
    .rd_addr ({i_r, j_r}),
    .rd_data (coef_rdata)
  );

  // ---------------------------------------------------------------- multiply
  // y step at row start (not the first row), x step per term after the first of a row, coefficient product per term
  always_comb begin
    mreq.start = ((state_r == S_ROW) && (j_r != '0)) ||
                 ((state_r == S_TERM) && (i_r != '0)) ||
                 (state_r == S_CMUL);
    mreq.a     = (state_r == S_ROW) ? ypow_r : xpow_r;
    case (state_r)
      S_ROW:   mreq.b = {{(CW-XW){y_r[XW-1]}}, y_r};
      S_TERM:  mreq.b = {{(CW-XW){x_r[XW-1]}}, x_r};
      default: mreq.b = coef_rdata;
    endcase
  end

  p2d_mulsh u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // saturating accumulate of the finished term
  assign acc_sum = acc_r + mrsp.res;
  assign acc_ovf = (acc_r[AW-1] == mrsp.res[AW-1]) && (acc_sum[AW-1] != acc_r[AW-1]);
  assign acc_nxt = acc_ovf ? (acc_r[AW-1] ? p2d_pkg::SAT_MIN : p2d_pkg::SAT_MAX)
                           : acc_sum;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      poly_order_r <= '0;
      full_grid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      sat_r        <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (p2d_pkg::reg_idx_t'(cfg_paddr[2]))
          p2d_pkg::REG_POLY_ORDER: poly_order_r <= cfg_pwdata[IW-1:0];
          p2d_pkg::REG_FULL_GRID:  full_grid_r  <= cfg_pwdata[0];
          default: ;
        endcase
      end

      // output register: load a finished value, or drop the taken beat
      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (p2d_pkg::mode_t'(in_tuser) == p2d_pkg::MODE_EVAL)) begin
            x_r     <= in_tdata[61:38];
            y_r     <= in_tdata[85:62];
            ypow_r  <= p2d_pkg::ONE_Q;
            acc_r   <= '0;
            sat_r   <= 1'b0;
            i_r     <= '0;
            j_r     <= '0;
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          i_r <= '0;
          if (j_r == '0) begin
            xpow_r  <= ypow_r;
            state_r <= S_TERM;
          end else begin
            state_r <= S_YWAIT;
          end
        end
        S_YWAIT: begin
          if (mrsp.done) begin
            ypow_r  <= mrsp.res;
            xpow_r  <= mrsp.res;
            sat_r   <= sat_r | mrsp.sat;
            state_r <= S_TERM;
          end
        end
        S_TERM: begin
          // coefficient read is issued here, data ready in S_CMUL
          state_r <= (i_r == '0) ? S_CMUL : S_XWAIT;
        end
        S_XWAIT: begin
          if (mrsp.done) begin
            xpow_r  <= mrsp.res;
            sat_r   <= sat_r | mrsp.sat;
            state_r <= S_CMUL;
          end
        end
        S_CMUL: begin
          state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          if (mrsp.done) begin
            acc_r <= acc_nxt;
            sat_r <= sat_r | mrsp.sat | acc_ovf;
            if (i_r != ilim) begin
              i_r     <= i_r + 1'b1;
              state_r <= S_TERM;
            end else if (j_r != ord) begin
              i_r     <= '0;
              j_r     <= j_r + 1'b1;
              state_r <= S_ROW;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_value_r <= acc_r;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_sat_r;

  // ---------------------------------------------------------------- checks
  // the shared multiplier never gets a new operation while one is in flight
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> !mrsp.busy)
    else $error("multiply started while busy");

  // every multiply answers after its fixed latency
  a_mul_lat: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> ##4 mrsp.done)
    else $error("multiply result missing");

  // term indexes stay within the active term set
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((j_r <= ord) && (i_r <= ilim)))
    else $error("term index out of range");

  // a new result appears only on leaving the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result without evaluation");

endmodule

>>> verif/tb_poly2d_evaluator.sv
module tb_poly2d_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let a trailing load beat retire before a register write
  localparam int LOAD_SETTLE = 8;
  // longest evaluation is order 7, full grid
  localparam int END_SETTLE = 700;
  // cycles with no beat on any port before the run is called hung
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 47;

  localparam logic [23:0] COORD_MAX = 24'h7FFFFF;
  localparam logic [23:0] COORD_MIN = 24'h800000;
  localparam logic [23:0] COORD_ONE = 24'h100000;
  localparam logic [23:0] COORD_HALF = 24'h080000;
  localparam logic [23:0] COORD_NEG_ONE = 24'hF00000;
  localparam logic [31:0] COEF_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] COEF_MIN = 32'h80000000;

  typedef struct {
    logic [63:0] value;
    logic        saturated;
  } poly_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [87:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the block: coefficient store and the two registers
  logic [31:0] coef_mem [p2d_pkg::DEPTH];
  logic [2:0]  order_cfg = '0;
  logic        grid_cfg = 1'b0;

  // values still owed by the block, oldest first
  poly_result_t pending_values [$];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  // when set, that side never idles
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;

  always #6 clk = ~clk;

  poly2d_evaluator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------
  // fixed point arithmetic of the evaluator
  // ---------------------------------------------------------------------

  // exact product, arithmetic shift back to Q.20, saturate to 64 bits
  function automatic logic [63:0] fix_mul(input logic signed [63:0] a,
                                          input logic signed [63:0] b,
                                          inout logic sat);
    logic signed [127:0] wa, wb, prod, scaled;
    wa = a;
    wb = b;
    prod = wa * wb;
    scaled = prod >>> p2d_pkg::FRAC_BITS;
    if (scaled[127:63] != {65{scaled[127]}}) begin
      sat = 1'b1;
      return scaled[127] ? p2d_pkg::SAT_MIN : p2d_pkg::SAT_MAX;
    end
    return scaled[63:0];
  endfunction

  function automatic logic [63:0] fix_add(input logic [63:0] a, input logic [63:0] b,
                                          inout logic sat);
    logic [63:0] sum;
    sum = a + b;
    // same-sign operands with a sign flip in the sum: overflow
    if (a[63] == b[63] && sum[63] != a[63]) begin
      sat = 1'b1;
      return a[63] ? p2d_pkg::SAT_MIN : p2d_pkg::SAT_MAX;
    end
    return sum;
  endfunction

  // polynomial value at one point with the current registers and store
  function automatic void poly_value_at(input logic [23:0] x_coord,
                                        input logic [23:0] y_coord,
                                        output logic [63:0] acc,
                                        output logic sat);
    logic signed [63:0] x_w, y_w, y_pow, x_pow, coef_w, term;
    int ord, last_i;
    x_w = $signed(x_coord);
    y_w = $signed(y_coord);
    ord = order_cfg;
    if (ord > p2d_pkg::MAX_ORDER) ord = p2d_pkg::MAX_ORDER;
    acc = '0;
    sat = 1'b0;
    y_pow = p2d_pkg::ONE_Q;
    // rows by y power, x power chained from the row's y power
    for (int j = 0; j <= ord; j++) begin
      if (j > 0) y_pow = fix_mul(y_pow, y_w, sat);
      x_pow = y_pow;
      last_i = grid_cfg ? ord : ord - j;
      for (int i = 0; i <= last_i; i++) begin
        if (i > 0) x_pow = fix_mul(x_pow, x_w, sat);
        coef_w = $signed(coef_mem[i * 8 + j]);
        term = fix_mul(coef_w, x_pow, sat);
        acc = fix_add(acc, term, sat);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // monitor: every handshake seen at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    poly_result_t want, got;
    logic active;
    if (rst_n) begin
      active = 1'b0;
      // result beat against the oldest owed value
      if (out_tvalid && out_tready) begin
        active = 1'b1;
        if (pending_values.size() == 0) begin
          $error("result beat with nothing owed: value %h saturated %b",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = pending_values.pop_front();
          got.value = out_tdata;
          got.saturated = out_tuser;
          if (got.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, got.value);
            fail_count++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, got.saturated);
            fail_count++;
          end
        end
      end
      // input beat: load updates the store, evaluate owes one value
      if (in_tvalid && in_tready) begin
        active = 1'b1;
        if (in_tuser == p2d_pkg::MODE_LOAD) begin
          coef_mem[{in_tdata[2:0], in_tdata[5:3]}] = in_tdata[37:6];
        end else begin
          poly_value_at(in_tdata[61:38], in_tdata[85:62], want.value, want.saturated);
          pending_values.push_back(want);
        end
      end
      // register write lands on this edge
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        active = 1'b1;
        case (p2d_pkg::reg_idx_t'(cfg_paddr[2]))
          p2d_pkg::REG_POLY_ORDER: order_cfg = cfg_pwdata[2:0];
          p2d_pkg::REG_FULL_GRID:  grid_cfg = cfg_pwdata[0];
          default: ;
        endcase
      end
      // hang detection
      if (active) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // random idling
  // ---------------------------------------------------------------------

  // mostly short, now and then long
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls on out_tready unless held steady
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) hold = random_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // one input beat; valid stays high into the next call unless a gap follows
  task automatic send_beat(p2d_pkg::mode_t mode, logic [2:0] x_power, logic [2:0] y_power,
                           logic [31:0] coef, logic [23:0] x_coord, logic [23:0] y_coord);
    int gap;
    @(negedge clk);
    in_tuser = mode;
    in_tdata = {2'b00, y_coord, x_coord, coef, y_power, x_power};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : random_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // point fields carry noise on a load, as do the load fields on an evaluate
  task automatic load_coef(logic [2:0] x_power, logic [2:0] y_power, logic [31:0] coef);
    send_beat(p2d_pkg::MODE_LOAD, x_power, y_power, coef, 24'($urandom), 24'($urandom));
  endtask

  task automatic eval_point(logic [23:0] x_coord, logic [23:0] y_coord);
    send_beat(p2d_pkg::MODE_EVAL, 3'($urandom), 3'($urandom), $urandom, x_coord, y_coord);
  endtask

  task automatic write_reg(p2d_pkg::reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // sender stops until every owed value is back and a trailing load is done
  task automatic settle_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (LOAD_SETTLE) @(negedge clk);
  endtask

  task automatic set_config(logic [2:0] order, logic grid);
    settle_idle();
    write_reg(p2d_pkg::REG_POLY_ORDER, 32'(order));
    write_reg(p2d_pkg::REG_FULL_GRID, 32'(grid));
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: return COORD_MAX;
          1: return COORD_MIN;
          default: return '0;
        endcase
      end
      // within +-2.0, keeps high powers in range
      1, 2, 3, 4: return 24'($urandom_range(0, 1 << 22)) - 24'(1 << 21);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      1, 2, 3, 4, 5: return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // every store entry written before any evaluation can read it,
  // then one point with the registers as they come out of reset
  task automatic test_store_fill();
    for (int k = 0; k < p2d_pkg::DEPTH; k++) load_coef(3'(k >> 3), 3'(k), rand_coef());
    eval_point(rand_coord(), rand_coord());
  endtask

  // extremes of coordinates and coefficients, both term sets, both order
  // limits, saturating terms and sticky saturation
  task automatic test_corner_points();
    set_config(3'd7, 1'b1);
    load_coef(3'd7, 3'd7, COEF_MAX);
    load_coef(3'd0, 3'd0, COEF_MIN);
    load_coef(3'd7, 3'd0, COEF_MAX);
    load_coef(3'd0, 3'd7, COEF_MIN);
    eval_point('0, '0);
    eval_point(COORD_MAX, COORD_MAX);
    eval_point(COORD_MIN, COORD_MIN);
    eval_point(COORD_MAX, COORD_MIN);
    eval_point(COORD_MIN, COORD_MAX);
    eval_point(COORD_ONE, COORD_ONE);
    eval_point(COORD_NEG_ONE, COORD_HALF);
    set_config(3'd7, 1'b0);
    eval_point(COORD_MAX, COORD_MAX);
    eval_point(COORD_MIN, COORD_MIN);
    set_config(3'd0, 1'b0);
    eval_point(COORD_MAX, COORD_MIN);
    set_config(3'd0, 1'b1);
    eval_point(COORD_MIN, COORD_MAX);
    set_config(3'd4, 1'b0);
    load_coef(3'd3, 3'd4, '0);
    load_coef(3'd4, 3'd3, 32'hFFFFFFFF);
    eval_point(COORD_ONE, COORD_NEG_ONE);
  endtask

  // back-to-back points, the sender holds off until all values are back
  task automatic test_pause_for_results();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    set_config(3'd3, 1'b1);
    for (int k = 0; k < 6; k++) eval_point(rand_coord(), rand_coord());
    settle_idle();
    for (int k = 0; k < 6; k++) eval_point(rand_coord(), rand_coord());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // phases of random loads and points under changing registers
  task automatic test_random_traffic();
    logic [2:0] order;
    logic grid;
    for (int p = 0; p < PHASES; p++) begin
      // first four phases sweep both order limits with both term sets
      if (p < 4) begin
        order = p[0] ? 3'd7 : 3'd0;
        grid = p[1];
      end else begin
        order = 3'($urandom_range(0, 7));
        grid = 1'($urandom_range(0, 1));
      end
      set_config(order, grid);
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 55)
          eval_point(rand_coord(), rand_coord());
        else
          load_coef(3'($urandom), 3'($urandom), rand_coef());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin : main_sequence
    // synchronous reset, released at a falling edge
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_store_fill();
    test_corner_points();
    test_pause_for_results();
    test_random_traffic();

    // drain, then leave room for anything stray to show up
    settle_idle();
    repeat (END_SETTLE) @(negedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
